### hw/rtl/msp_v1_frame_encoder_defines.svh
// Assertion macros shared by the MSP v1 frame encoder RTL
`ifndef MSP_V1_FRAME_ENCODER_DEFINES_SVH
`define MSP_V1_FRAME_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/msp_pkg.sv
// Package: constants, types and helpers of the MSP v1 frame encoder
package msp_pkg;

    localparam logic [7:0] MAX_PAYLOAD = 8'd255;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] SYNC_DOLLAR = 8'h24;
    localparam logic [7:0] SYNC_M      = 8'h4D;
    localparam logic [7:0] DIR_REPLY   = 8'h3E;

    localparam int          APB_AW     = 3;
    localparam logic        REG_ENABLE = 1'b0;

    typedef enum logic [2:0] {
        HDR_DOLLAR,
        HDR_M,
        HDR_DIR,
        HDR_LEN,
        HDR_CODE
    } hdr_idx_t;

    typedef struct packed {
        logic       hdr;
        logic       pay;
        logic       last;
        logic [7:0] code;
        logic [7:0] len;
        logic [7:0] data;
        logic [7:0] cks;
    } msp_op_t;

    function automatic logic [7:0] hdr_byte(hdr_idx_t idx, msp_op_t op);
        logic [7:0] b;
        case (idx)
            HDR_DOLLAR: b = SYNC_DOLLAR;
            HDR_M:      b = SYNC_M;
            HDR_DIR:    b = DIR_REPLY;
            HDR_LEN:    b = op.len;
            HDR_CODE:   b = op.code;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/msp_in_if.sv
// Interface: input item channel (payload byte plus message marks)
interface msp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_code;
    logic [7:0] msg_len;
    logic [7:0] data_byte;
    logic       is_first;
    logic       is_last;

    modport source (output valid, msg_code, msg_len, data_byte, is_first, is_last,
                    input ready);
    modport sink   (input valid, msg_code, msg_len, data_byte, is_first, is_last,
                    output ready);
endinterface

### hw/rtl/msp_out_if.sv
// Interface: output byte channel of the serialized frame
interface msp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, out_byte, frame_end, input ready);
    modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

### hw/rtl/msp_front.sv
// Front end: accepts items, tracks checksum/count/limit, issues byte-group ops
module msp_front
(
    input  logic               clk,
    input  logic               rst_n,
    msp_in_if.sink             in_ch,
    input  logic               enable,
    input  logic               fifo_full,
    output logic               push,
    output msp_pkg::msp_op_t   op
);

    logic [7:0] cks_reg, cks_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] lim_reg, lim_next;

    logic [7:0] cks_base;
    logic [7:0] cnt_base;
    logic [7:0] lim_base;
    logic [7:0] lim_first;
    logic       take;
    logic       fire;

    assign in_ch.ready = !fifo_full;
    assign fire        = in_ch.valid && in_ch.ready && enable;

    always_comb
    begin
        lim_first = (in_ch.msg_len > msp_pkg::MAX_PAYLOAD) ? msp_pkg::MAX_PAYLOAD
                                                           : in_ch.msg_len;
        cks_base  = in_ch.is_first ? (in_ch.msg_len ^ in_ch.msg_code) : cks_reg;
        cnt_base  = in_ch.is_first ? 8'd0 : cnt_reg;
        lim_base  = in_ch.is_first ? lim_first : lim_reg;
        take      = (cnt_base < lim_base);
        cks_next  = cks_reg;
        cnt_next  = cnt_reg;
        lim_next  = lim_reg;
        if (fire)
        begin
            cks_next = take ? (cks_base ^ in_ch.data_byte) : cks_base;
            cnt_next = cnt_base + {7'd0, take};
            lim_next = lim_base;
        end
    end

    always_comb
    begin
        op.hdr  = in_ch.is_first;
        op.pay  = take;
        op.last = in_ch.is_last;
        op.code = in_ch.msg_code;
        op.len  = in_ch.msg_len;
        op.data = in_ch.data_byte;
        op.cks  = take ? (cks_base ^ in_ch.data_byte) : cks_base;
        push    = fire && (in_ch.is_first || take || in_ch.is_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cks_reg <= 8'd0;
            cnt_reg <= 8'd0;
            lim_reg <= 8'd0;
        end
        else
        begin
            cks_reg <= cks_next;
            cnt_reg <= cnt_next;
            lim_reg <= lim_next;
        end
    end

endmodule

### hw/rtl/msp_fifo.sv
// Op queue between front end and byte emitter
`include "msp_v1_frame_encoder_defines.svh"

module msp_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  msp_pkg::msp_op_t   push_op,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output msp_pkg::msp_op_t   head_op
);

    msp_pkg::msp_op_t                 mem_reg [msp_pkg::FIFO_DEPTH];
    logic [msp_pkg::FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [msp_pkg::FIFO_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [msp_pkg::FIFO_AW:0]        count_reg, count_next;

    assign full       = (count_reg == (msp_pkg::FIFO_AW + 1)'(msp_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `MSP_ASSERT_NOW(a_no_overflow, push && !pop, !full, "op queue overflow")
    `MSP_ASSERT_NOW(a_no_underflow, pop, head_valid, "op queue underflow")

endmodule

### hw/rtl/msp_back.sv
// Back end: expands queued ops into frame bytes behind an output register
`include "msp_v1_frame_encoder_defines.svh"

module msp_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  msp_pkg::msp_op_t   head_op,
    output logic               pop,
    msp_out_if.source          out_ch
);

    msp_pkg::msp_op_t   cur_reg, cur_next;
    msp_pkg::hdr_idx_t  hdr_idx_reg, hdr_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               frame_end_reg, frame_end_next;

    msp_pkg::msp_op_t   rem;
    logic               slot_free;
    logic               emit;
    logic [7:0]         byte_sel;
    logic               end_sel;

    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        rem          = cur_reg;
        hdr_idx_next = hdr_idx_reg;
        emit         = 1'b0;
        byte_sel     = 8'd0;
        end_sel      = 1'b0;
        if (slot_free)
        begin
            if (rem.hdr)
            begin
                emit     = 1'b1;
                byte_sel = msp_pkg::hdr_byte(hdr_idx_reg, cur_reg);
                if (hdr_idx_reg == msp_pkg::HDR_CODE)
                begin
                    rem.hdr      = 1'b0;
                    hdr_idx_next = msp_pkg::HDR_DOLLAR;
                end
                else
                begin
                    hdr_idx_next = msp_pkg::hdr_idx_t'(hdr_idx_reg + 3'd1);
                end
            end
            else if (rem.pay)
            begin
                emit     = 1'b1;
                byte_sel = cur_reg.data;
                rem.pay  = 1'b0;
            end
            else if (rem.last)
            begin
                emit     = 1'b1;
                byte_sel = cur_reg.cks;
                end_sel  = 1'b1;
                rem.last = 1'b0;
            end
        end
        pop      = head_valid && !(rem.hdr || rem.pay || rem.last);
        cur_next = pop ? head_op : rem;
    end

    always_comb
    begin
        out_valid_next = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
        out_byte_next  = emit ? byte_sel : out_byte_reg;
        frame_end_next = emit ? end_sel : frame_end_reg;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.frame_end = frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            hdr_idx_reg   <= msp_pkg::HDR_DOLLAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            hdr_idx_reg   <= hdr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        frame_end_reg <= frame_end_next;
    end

    `MSP_ASSERT_NOW(a_hdr_pending, hdr_idx_reg != msp_pkg::HDR_DOLLAR, cur_reg.hdr, "header index without header")
    `MSP_ASSERT_NOW(a_end_after_body, emit && end_sel, !cur_reg.hdr && !cur_reg.pay, "frame end before body done")

endmodule

### hw/rtl/msp_v1_frame_encoder.sv
// Top level: MSP v1 frame encoder with APB enable register
//
//   channel   dir   handshake            carries
//   in_ch     in    valid/ready          msg_code, msg_len, data_byte, is_first, is_last
//   out_ch    out   valid/ready          out_byte, frame_end
//   apb       in    psel/penable/pready  enable register at byte addresses 0 to 3
//
// One output byte per cycle while out_ch is ready; an item makes 0 to 7
// bytes: a header item makes 5 to 7, an item without a header at most 2.
// A 4-entry op queue lets the front end keep taking items while bytes drain.
// in_ch.ready drops only when the op queue is full; out_ch stalls hold the
// output register and back-pressure through the queue.
// Reset clears enable, checksum, count, limit and the queue.
module msp_v1_frame_encoder
(
    input  logic                          clk,
    input  logic                          rst_n,
    msp_in_if.sink                        in_ch,
    msp_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msp_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic               enable_reg, enable_next;
    logic               reg_hit;
    logic               fifo_full;
    logic               push;
    logic               pop;
    logic               head_valid;
    msp_pkg::msp_op_t   push_op;
    msp_pkg::msp_op_t   head_op;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[msp_pkg::APB_AW-1] == msp_pkg::REG_ENABLE);
    assign prdata  = reg_hit ? {31'd0, enable_reg} : 32'd0;

    always_comb
    begin
        enable_next = enable_reg;
        if (psel && penable && pwrite && pready && reg_hit)
            enable_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b0;
        else
            enable_reg <= enable_next;
    end

    msp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .enable    (enable_reg),
        .fifo_full (fifo_full),
        .push      (push),
        .op        (push_op)
    );

    msp_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .pop        (pop),
        .full       (fifo_full),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    msp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule
